### rtl/midi_clock_and_timecode_generator_core_defines.svh
// Assertion macros shared by the MIDI clock and timecode generator RTL.
`ifndef MIDI_CLOCK_AND_TIMECODE_GENERATOR_CORE_DEFINES_SVH
`define MIDI_CLOCK_AND_TIMECODE_GENERATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle property, checked out of reset
`define MCTG_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("mctg assertion failed");

// Antecedent now, consequent on the next edge
`define MCTG_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mctg assertion failed");

`else

`define MCTG_ASSERT(lbl, ck, rn, prop)
`define MCTG_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

### rtl/mctg_pkg.sv
// Types, constants and message tables for the MIDI clock and timecode generator.
package mctg_pkg;

    // Frame position bits used by the modulo unit
    localparam int POSITION_BITS = 32;
    localparam int FIELD_POS_W   = 32;
    localparam int POS_W  = (POSITION_BITS < FIELD_POS_W) ? POSITION_BITS : FIELD_POS_W;
    localparam int STEP_W = $clog2(POS_W);

    // Configuration widths
    localparam int MODE_W = 2;
    localparam int FPC_W  = 16;
    localparam int RATE_W = 20;
    localparam int FPS_W  = 5;
    localparam int DIV_W  = RATE_W;
    localparam int CFG_W  = 20;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FPC       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TC_RATE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TC_FPS    = 2'd3;

    localparam logic [FPS_W-1:0] FPS_RESET = 5'd25;

    // Sync modes
    localparam logic [MODE_W-1:0] MODE_CLOCK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MTC   = 2'd2;

    // Actions
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_REWIND = 2'd1;
    localparam logic [1:0] ACT_START  = 2'd2;
    localparam logic [1:0] ACT_STOP   = 2'd3;

    // MIDI bytes
    localparam logic [7:0] ST_CLOCK   = 8'hF8;
    localparam logic [7:0] ST_QFRAME  = 8'hF1;
    localparam logic [7:0] ST_SYSEX   = 8'hF0;
    localparam logic [7:0] ST_EOX     = 8'hF7;
    localparam logic [7:0] ST_SONGPOS = 8'hF2;
    localparam logic [7:0] ST_START   = 8'hFA;
    localparam logic [7:0] ST_STOP    = 8'hFC;
    localparam logic [7:0] FULL_SUB1  = 8'h01;
    localparam logic [6:0] SYSEX_RT   = 7'h7F;
    localparam logic [6:0] FULL_SUB2  = 7'h01;

    localparam logic [5:0] SIXTY = 6'd60;

    // Message sets one item can produce
    typedef enum logic [2:0] {
        K_NONE, K_CLOCK, K_QF_LO, K_QF_HI, K_FULL, K_SPP, K_START, K_STOP
    } plan_t;

    typedef struct packed {
        logic [1:0]             action;
        logic [FIELD_POS_W-1:0] frame_position;
        logic                   clock_waiting;
    } evt_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic [1:0] data_count;
        logic       last_message;
    } msg_t;

    typedef struct packed {
        logic [4:0] frame;
        logic [5:0] second;
        logic [5:0] minute;
        logic [7:0] hour;
    } tc_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
        logic has_msgs;
        logic out_free;
        logic last_idx;
    } dp_status_t;

    function automatic logic [2:0] msg_count(input plan_t k);
        logic [2:0] n;
        case (k)
            K_CLOCK, K_SPP, K_STOP:    n = 3'd1;
            K_START:                   n = 3'd2;
            K_QF_LO, K_QF_HI, K_FULL:  n = 3'd4;
            default:                   n = 3'd0;
        endcase
        return n;
    endfunction

    // Message idx of set k; last_message is filled in by the caller
    function automatic msg_t build_msg(input plan_t k, input logic [1:0] idx, input tc_t tc);
        msg_t       m;
        logic [2:0] piece;
        logic [3:0] nib;
        m     = '0;
        piece = {(k == K_QF_HI), idx};
        case (piece)
            3'd0:    nib = tc.frame[3:0];
            3'd1:    nib = {3'b000, tc.frame[4]};
            3'd2:    nib = tc.second[3:0];
            3'd3:    nib = {2'b00, tc.second[5:4]};
            3'd4:    nib = tc.minute[3:0];
            3'd5:    nib = {2'b00, tc.minute[5:4]};
            3'd6:    nib = tc.hour[3:0];
            default: nib = tc.hour[7:4];
        endcase
        case (k)
            K_CLOCK: m.status_byte = ST_CLOCK;
            K_QF_LO, K_QF_HI:
            begin
                m.status_byte = ST_QFRAME;
                m.data_one    = {piece, nib};
                m.data_count  = 2'd1;
            end
            K_FULL:
            begin
                case (idx)
                    2'd0:
                    begin
                        m.status_byte = ST_SYSEX;
                        m.data_one    = SYSEX_RT;
                        m.data_count  = 2'd2;
                    end
                    2'd1:
                    begin
                        m.status_byte = FULL_SUB1;
                        m.data_one    = FULL_SUB2;
                        m.data_count  = 2'd2;
                    end
                    2'd2:    m.data_count  = 2'd2;
                    default: m.status_byte = ST_EOX;
                endcase
            end
            K_SPP:
            begin
                m.status_byte = ST_SONGPOS;
                m.data_count  = 2'd2;
            end
            K_START:
            begin
                if (idx == 2'd0)
                begin
                    m.status_byte = ST_START;
                end
                else
                begin
                    m.status_byte = ST_SONGPOS;
                    m.data_count  = 2'd2;
                end
            end
            K_STOP:  m.status_byte = ST_STOP;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

### rtl/mctg_ctrl.sv
// Sequencing controller: accept, modulo steps, plan, message send.
`include "midi_clock_and_timecode_generator_core_defines.svh"

module mctg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 evt_valid,
    output logic                 evt_stall,
    input  mctg_pkg::dp_status_t st,
    output mctg_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_PLAN = 4'b0100,
        S_SEND = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (evt_valid) state_next = S_DIV;
            S_DIV:  if (st.div_last) state_next = S_PLAN;
            S_PLAN: state_next = st.has_msgs ? S_SEND : S_IDLE;
            S_SEND: if (st.out_free && st.last_idx) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Commands
    assign evt_stall    = (state_reg != S_IDLE);
    assign cmd.load     = (state_reg == S_IDLE) && evt_valid;
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.commit   = (state_reg == S_PLAN);
    assign cmd.out_load = (state_reg == S_SEND) && st.out_free;

    `MCTG_ASSERT_NEXT(a_accept_blocks, clk, rst_n, evt_valid && !evt_stall, evt_stall)
    `MCTG_ASSERT_NEXT(a_last_to_idle, clk, rst_n, cmd.out_load && st.last_idx, state_reg == S_IDLE)

endmodule

### rtl/mctg_dp.sv
// Datapath: config registers, serial modulo unit, timecode counters, output word.
`include "midi_clock_and_timecode_generator_core_defines.svh"

module mctg_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mctg_pkg::evt_t                       evt,
    input  logic                                 cfg_we,
    input  logic [mctg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mctg_pkg::CFG_W-1:0]           cfg_data,
    input  mctg_pkg::dp_cmd_t                    cmd,
    output mctg_pkg::dp_status_t                 st,
    output logic                                 msg_valid,
    input  logic                                 msg_stall,
    output mctg_pkg::msg_t                       msg
);

    // Configuration
    logic [mctg_pkg::MODE_W-1:0] sync_mode_reg;
    logic [mctg_pkg::FPC_W-1:0]  fpc_reg;
    logic [mctg_pkg::RATE_W-1:0] rate_reg;
    logic [mctg_pkg::FPS_W-1:0]  fps_reg;

    // Item and modulo unit
    logic [1:0]                  action_reg;
    logic                        waiting_reg;
    logic [mctg_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [mctg_pkg::DIV_W-1:0]  rem_reg, rem_next;
    logic [mctg_pkg::STEP_W-1:0] step_reg;
    logic [mctg_pkg::DIV_W-1:0]  divisor;
    logic [mctg_pkg::DIV_W:0]    trial;

    // Timecode and message sequencing
    mctg_pkg::tc_t               tc_reg, tc_next, snap_reg, tc_adv;
    mctg_pkg::plan_t             plan_reg, plan_calc;
    logic [1:0]                  idx_reg;
    logic                        msg_valid_reg;
    mctg_pkg::msg_t              msg_reg, msg_next;
    logic                        clock_m, mtc_m, rem_zero, do_adv, do_clear;
    logic [4:0]                  frame_inc;
    logic [5:0]                  sec_inc, min_inc;
    logic [2:0]                  plan_len;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_mode_reg <= '0;
            fpc_reg       <= '0;
            rate_reg      <= '0;
            fps_reg       <= mctg_pkg::FPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mctg_pkg::REG_SYNC_MODE: sync_mode_reg <= cfg_data[mctg_pkg::MODE_W-1:0];
                mctg_pkg::REG_FPC:       fpc_reg       <= cfg_data[mctg_pkg::FPC_W-1:0];
                mctg_pkg::REG_TC_RATE:   rate_reg      <= cfg_data[mctg_pkg::RATE_W-1:0];
                mctg_pkg::REG_TC_FPS:    fps_reg       <= cfg_data[mctg_pkg::FPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign clock_m = (sync_mode_reg == mctg_pkg::MODE_CLOCK);
    assign mtc_m   = (sync_mode_reg == mctg_pkg::MODE_MTC);

    // Restoring modulo, one position bit per step, MSB first
    assign divisor = clock_m ? {{(mctg_pkg::DIV_W-mctg_pkg::FPC_W){1'b0}}, fpc_reg} : rate_reg;
    assign trial   = {rem_reg, pos_reg[mctg_pkg::POS_W-1]};

    always_comb
    begin
        if (trial >= {1'b0, divisor})
            rem_next = mctg_pkg::DIV_W'(trial - {1'b0, divisor});
        else
            rem_next = trial[mctg_pkg::DIV_W-1:0];
        pos_next = {pos_reg[mctg_pkg::POS_W-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg  <= evt.action;
            waiting_reg <= evt.clock_waiting;
            pos_reg     <= evt.frame_position[mctg_pkg::POS_W-1:0];
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            pos_reg <= pos_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.load || st.div_last)
            step_reg <= '0;
        else if (cmd.div_step)
            step_reg <= step_reg + mctg_pkg::STEP_W'(1);
    end

    assign st.div_last = cmd.div_step && (step_reg == mctg_pkg::STEP_W'(mctg_pkg::POS_W - 1));
    assign rem_zero    = (rem_reg == '0);

    // Decide the message set and the counter update
    always_comb
    begin
        plan_calc = mctg_pkg::K_NONE;
        do_adv    = 1'b0;
        do_clear  = 1'b0;
        case (action_reg)
            mctg_pkg::ACT_TICK:
            begin
                if (!waiting_reg)
                begin
                    if (clock_m)
                    begin
                        if (fpc_reg != '0 && rem_zero)
                            plan_calc = mctg_pkg::K_CLOCK;
                    end
                    else if (mtc_m)
                    begin
                        if (rate_reg != '0 && rem_zero)
                        begin
                            plan_calc = tc_reg.frame[0] ? mctg_pkg::K_QF_HI : mctg_pkg::K_QF_LO;
                            do_adv    = 1'b1;
                        end
                    end
                end
            end
            mctg_pkg::ACT_REWIND:
            begin
                do_clear = 1'b1;
                if (mtc_m)
                    plan_calc = mctg_pkg::K_FULL;
                else if (clock_m)
                    plan_calc = mctg_pkg::K_SPP;
            end
            mctg_pkg::ACT_START: if (clock_m) plan_calc = mctg_pkg::K_START;
            mctg_pkg::ACT_STOP:  if (clock_m) plan_calc = mctg_pkg::K_STOP;
            default: plan_calc = mctg_pkg::K_NONE;
        endcase
    end

    // Timecode advance: frames roll at fps, seconds and minutes at 60
    always_comb
    begin
        frame_inc = tc_reg.frame + 5'd1;
        sec_inc   = tc_reg.second + 6'd1;
        min_inc   = tc_reg.minute + 6'd1;
        tc_adv    = tc_reg;
        tc_adv.frame = frame_inc;
        if (frame_inc >= fps_reg)
        begin
            tc_adv.frame  = '0;
            tc_adv.second = sec_inc;
            if (sec_inc >= mctg_pkg::SIXTY)
            begin
                tc_adv.second = '0;
                tc_adv.minute = min_inc;
                if (min_inc >= mctg_pkg::SIXTY)
                begin
                    tc_adv.minute = '0;
                    tc_adv.hour   = tc_reg.hour + 8'd1;
                end
            end
        end
        if (do_clear)
            tc_next = '0;
        else if (do_adv)
            tc_next = tc_adv;
        else
            tc_next = tc_reg;
    end

    assign plan_len    = mctg_pkg::msg_count(plan_reg);
    assign st.has_msgs = (mctg_pkg::msg_count(plan_calc) != 3'd0);
    assign st.last_idx = ({1'b0, idx_reg} == (plan_len - 3'd1));
    assign st.out_free = !msg_valid_reg || !msg_stall;

    // Counters and sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg   <= '0;
            plan_reg <= mctg_pkg::K_NONE;
            idx_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            tc_reg   <= tc_next;
            plan_reg <= plan_calc;
            idx_reg  <= '0;
        end
        else if (cmd.out_load)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Nibbles come from the counts before the advance
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            snap_reg <= tc_reg;
    end

    // Output word register
    always_comb
    begin
        msg_next = mctg_pkg::build_msg(plan_reg, idx_reg, snap_reg);
        msg_next.last_message = st.last_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            msg_valid_reg <= 1'b0;
        else if (cmd.out_load)
            msg_valid_reg <= 1'b1;
        else if (!msg_stall)
            msg_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            msg_reg <= msg_next;
    end

    assign msg_valid = msg_valid_reg;
    assign msg       = msg_reg;

    `MCTG_ASSERT(a_no_overwrite, clk, rst_n, (msg_valid_reg && msg_stall) |-> !cmd.out_load)
    `MCTG_ASSERT(a_div_finished, clk, rst_n, cmd.commit |-> step_reg == '0)
    `MCTG_ASSERT_NEXT(a_tc_range, clk, rst_n, cmd.commit, tc_reg.second < mctg_pkg::SIXTY && tc_reg.minute < mctg_pkg::SIXTY)

endmodule

### rtl/midi_clock_and_timecode_generator_core.sv
// A word's first message is registered after acceptance, the 32 modulo steps, the plan state and a send state.
// evt_stall holds off new words until the last message is loaded, or past the plan state if it sends nothing.
// The bit-serial modulo unit takes one frame position bit per cycle.
// Messages of one word leave at one per cycle while the output is not stalled.
// Reset (rst_n low, async): counters cleared, sync off, timecode fps 25, no message pending.
module midi_clock_and_timecode_generator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           evt_valid,
    output logic                           evt_stall,
    input  mctg_pkg::evt_t                 evt,
    output logic                           msg_valid,
    input  logic                           msg_stall,
    output mctg_pkg::msg_t                 msg,
    input  logic                           cfg_we,
    input  logic [mctg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mctg_pkg::CFG_W-1:0]     cfg_data
);

    mctg_pkg::dp_cmd_t    cmd;
    mctg_pkg::dp_status_t st;

    // Controller
    mctg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .st        (st),
        .cmd       (cmd)
    );

    // Datapath
    mctg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg)
    );

endmodule
